@@ design/ftbo_pkg.sv @@
// Shared types, constants and blend arithmetic for the front-to-back over compositor.
// Used by ftbo_ctrl, ftbo_dp and front_to_back_over_compositor_core; depends on nothing.

package ftbo_pkg;

  // Accumulation store geometry (depth is a power of two; addresses wrap)
  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Item field widths
  localparam int IN_ADDR_W  = 16;
  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 32;
  localparam int PROD_W     = 2 * CH_W;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CALC = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // latch input item, start store read
    logic mul;     // capture stored pixel and channel products
    logic fin;     // divide, add, saturate into result register
    logic commit;  // write store, load output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // output register empty or being drained
  } status_t;

  // floor(p / 255) for p <= 255*255, via reciprocal form (p + (p >> 8) + 1) >> 8
  function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] t;
    t = {1'b0, p} + {{(CH_W+1){1'b0}}, p[PROD_W-1:CH_W]} + {{PROD_W{1'b0}}, 1'b1};
    return t[PROD_W-1:CH_W];
  endfunction

  // front + quotient, saturated at 255
  function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] f,
                                              input logic [CH_W-1:0] q);
    logic [CH_W:0] s;
    s = {1'b0, f} + {1'b0, q};
    return s[CH_W] ? CH_MAX : s[CH_W-1:0];
  endfunction

endpackage

@@ design/front_to_back_over_compositor_core.sv @@
// Top level of the front-to-back over compositor: controller plus datapath with store.
// Depends on ftbo_pkg, ftbo_ctrl, ftbo_dp (and ftbo_ram through it).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: pixel_address[15:0], new_pixel[47:16];
//          |     |                    | tuser: first_layer
//  m_      | out | m_tvalid/m_tready  | tdata: composite_pixel[31:0]
//
// Per item: store read at the accepting edge, then a multiply edge, a divide/add/saturate
// edge and a commit edge that writes back and loads the output register. The store's
// single read-then-write access per item keeps a new item out until the last one commits.
// rst (synchronous) clears the controller and output valid; store contents are undefined.
// A stalled output holds its item; one more item is accepted meanwhile, waits to commit,
// and holds s_tready low until the output frees.

module front_to_back_over_compositor_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ftbo_pkg::S_TDATA_W-1:0]    s_tdata,   // pixel_address, new_pixel
  input  logic                              s_tuser,   // first_layer
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ftbo_pkg::M_TDATA_W-1:0]    m_tdata    // composite_pixel
);

  ftbo_pkg::cmd_t    cmd;
  ftbo_pkg::status_t status;

  ftbo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ftbo_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .in_first  (s_tuser),
    .out_data  (m_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

endmodule

@@ design/ftbo_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module ftbo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ftbo_ctrl.sv @@
// Controller state machine for the compositor: sequences read, multiply, finish, commit.
// Depends on ftbo_pkg.

module ftbo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ftbo_pkg::status_t status,
  output ftbo_pkg::cmd_t    cmd
);

  ftbo_pkg::state_t state, state_next;

  // Decode commands from state
  always_comb begin
    in_ready   = (state == ftbo_pkg::S_IDLE);
    cmd.accept = in_ready && in_valid;
    cmd.mul    = (state == ftbo_pkg::S_READ);
    cmd.fin    = (state == ftbo_pkg::S_CALC);
    cmd.commit = (state == ftbo_pkg::S_DONE) && status.out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ftbo_pkg::S_IDLE: begin
        if (in_valid) state_next = ftbo_pkg::S_READ;
      end
      ftbo_pkg::S_READ: state_next = ftbo_pkg::S_CALC;
      ftbo_pkg::S_CALC: state_next = ftbo_pkg::S_DONE;
      ftbo_pkg::S_DONE: begin
        if (status.out_free) state_next = ftbo_pkg::S_IDLE;
      end
      default: state_next = ftbo_pkg::S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftbo_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // An accepted item runs read, then multiply, then finish, then waits to commit
  a_accept_then_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.mul) else $error("accept not followed by multiply step");
  a_mul_then_fin: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |=> cmd.fin) else $error("multiply not followed by finish step");
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul || cmd.fin) |-> !cmd.accept) else $error("item accepted while busy");

endmodule

@@ design/ftbo_dp.sv @@
// Datapath for the compositor: input latch, accumulation store, blend pipeline, output register.
// Depends on ftbo_pkg and ftbo_ram.

module ftbo_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  ftbo_pkg::cmd_t                    cmd,
  output ftbo_pkg::status_t                 status,
  input  logic [ftbo_pkg::S_TDATA_W-1:0]    in_data,
  input  logic                              in_first,
  output logic [ftbo_pkg::M_TDATA_W-1:0]    out_data,
  output logic                              out_valid,
  input  logic                              out_ready
);

  logic [ftbo_pkg::ADDR_W-1:0]  in_addr;
  logic [ftbo_pkg::PIX_W-1:0]   in_pix;
  logic [ftbo_pkg::ADDR_W-1:0]  addr_q;
  logic [ftbo_pkg::PIX_W-1:0]   pix_q;
  logic                         first_q;
  logic [ftbo_pkg::PIX_W-1:0]   rd_data;
  logic [ftbo_pkg::PIX_W-1:0]   front_q;
  logic [ftbo_pkg::PROD_W-1:0]  prod_q [ftbo_pkg::NUM_CH];
  logic [ftbo_pkg::PIX_W-1:0]   blend;
  logic [ftbo_pkg::PIX_W-1:0]   res_q;
  logic [ftbo_pkg::CH_W-1:0]    inv_alpha;

  // Unpack input item: address wraps to store depth
  assign in_addr = in_data[ftbo_pkg::ADDR_W-1:0];
  assign in_pix  = in_data[ftbo_pkg::IN_ADDR_W +: ftbo_pkg::PIX_W];

  ftbo_ram #(
    .WIDTH (ftbo_pkg::PIX_W),
    .DEPTH (ftbo_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (addr_q),
    .wdata (res_q),
    .re    (cmd.accept),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_q  <= in_addr;
      pix_q   <= in_pix;
      first_q <= in_first;
    end
  end

  // Multiply stage: (255 - front alpha) * back, per channel
  assign inv_alpha = ftbo_pkg::CH_MAX - rd_data[ftbo_pkg::PIX_W-1 -: ftbo_pkg::CH_W];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      front_q <= rd_data;
      for (int k = 0; k < ftbo_pkg::NUM_CH; k++) begin
        prod_q[k] <= {{ftbo_pkg::CH_W{1'b0}}, inv_alpha} *
                     {{ftbo_pkg::CH_W{1'b0}}, pix_q[k*ftbo_pkg::CH_W +: ftbo_pkg::CH_W]};
      end
    end
  end

  // Finish stage: divide by 255, add front, saturate; a first layer passes the new pixel through
  always_comb begin
    for (int k = 0; k < ftbo_pkg::NUM_CH; k++) begin
      blend[k*ftbo_pkg::CH_W +: ftbo_pkg::CH_W] =
        ftbo_pkg::sat_add(front_q[k*ftbo_pkg::CH_W +: ftbo_pkg::CH_W],
                          ftbo_pkg::div255(prod_q[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_q <= first_q ? pix_q : blend;
    end
  end

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= res_q;
    end
  end

  assign status.out_free = !out_valid || out_ready;

  // A commit shows the finished pixel on the output next cycle
  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid && (out_data == $past(res_q)))
    else $error("committed pixel not on output");
  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit would overwrite a waiting item");

endmodule

@@ verif/tb_front_to_back_over_compositor_core.sv @@
// Testbench for front_to_back_over_compositor_core: layer stacks of first-layer copies and
// over blends, checked item by item against a behavioral copy of the accumulation store.
// Depends on ftbo_pkg and the core RTL only.

module tb_front_to_back_over_compositor_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 8;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               s_tvalid;
  logic                               s_tready;
  logic [ftbo_pkg::S_TDATA_W-1:0]     s_tdata;   // pixel_address, new_pixel
  logic                               s_tuser;   // first_layer
  logic                               m_tvalid;
  logic                               m_tready;
  logic [ftbo_pkg::M_TDATA_W-1:0]     m_tdata;   // composite_pixel

  // Behavioral copy of the accumulation store
  logic [ftbo_pkg::PIX_W-1:0]         layer_store [ftbo_pkg::STORE_DEPTH];
  bit                                 written_mask [ftbo_pkg::STORE_DEPTH];
  logic [ftbo_pkg::IN_ADDR_W-1:0]     live_addrs [$];
  logic [ftbo_pkg::IN_ADDR_W-1:0]     last_addr;
  logic [ftbo_pkg::PIX_W-1:0]         pending_pixels [$];
  logic [ftbo_pkg::PIX_W-1:0]         expected_pixel;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int ready_hold_cycles = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  front_to_back_over_compositor_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Front pixel over back pixel, each byte saturated at 255, exact floor division
  function automatic logic [31:0] blend_over(input logic [31:0] front, input logic [31:0] back);
    logic [31:0] sum;
    logic [31:0] result;
    int k;
    result = '0;
    for (k = 0; k < ftbo_pkg::NUM_CH; k++) begin
      sum = front[8*k +: 8] + ((32'd255 - front[31:24]) * back[8*k +: 8]) / 32'd255;
      result[8*k +: 8] = (sum > 32'd255) ? 8'hFF : sum[7:0];
    end
    return result;
  endfunction

  // Offer one item, wait for the handshake, then update the store copy
  task automatic send_pixel(input logic [15:0] addr, input logic [31:0] pix,
                            input logic first);
    logic [31:0] result;
    int unsigned slot;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pix, addr};
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    slot = addr % ftbo_pkg::STORE_DEPTH;
    result = first ? pix : blend_over(layer_store[slot], pix);
    layer_store[slot] = result;
    if (!written_mask[slot]) begin
      written_mask[slot] = 1'b1;
      live_addrs.push_back(addr);
    end
    last_addr = addr;
    pending_pixels.push_back(result);
  endtask

  // Mostly continue the current layer stack; sometimes start a new one
  task automatic send_random_item();
    logic [15:0] addr;
    logic [31:0] pix;
    int unsigned roll;
    int unsigned mode;
    roll = $urandom_range(0, 99);
    mode = $urandom_range(0, 9);
    pix = $urandom();
    if (mode < 2) begin
      pix[31:24] = 8'h00;
    end else if (mode < 4) begin
      pix[31:24] = 8'hFF;
    end else if (mode == 4) begin
      pix = pix | 32'h00C0C0C0;
    end else if (mode == 5) begin
      pix = ($urandom_range(0, 1) != 0) ? 32'hFFFFFFFF : 32'h00000000;
    end
    if (live_addrs.size() == 0 || roll < 25) begin
      addr = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 15));
      send_pixel(addr, pix, 1'b1);
    end else begin
      addr = (roll < 65) ? last_addr : live_addrs[$urandom_range(0, live_addrs.size() - 1)];
      send_pixel(addr, pix, 1'b0);
    end
  endtask

  // Address and pixel extremes, saturation, opaque and clear fronts, same-address bursts
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_pixel(16'h0000, 32'h00000000, 1'b1);
    send_pixel(16'hFFFF, 32'hFFFFFFFF, 1'b1);
    send_pixel(16'h0000, 32'hFFFFFFFF, 1'b0);
    send_pixel(16'hFFFF, 32'h12345678, 1'b0);
    send_pixel(16'h5555, 32'h00C8C8C8, 1'b1);
    send_pixel(16'h5555, 32'hFFC8C8C8, 1'b0);
    send_pixel(16'hAAAA, 32'h80402010, 1'b1);
    send_pixel(16'hAAAA, 32'h80FF7F01, 1'b0);
    send_pixel(16'hAAAA, 32'hFFFFFFFF, 1'b0);
    send_pixel(16'hAAAA, 32'h00000000, 1'b0);
    send_pixel(16'h0001, 32'h7F000000, 1'b1);
    send_pixel(16'h0001, 32'h01010101, 1'b0);
    send_pixel(16'h1234, 32'h3300FF00, 1'b1);
    send_pixel(16'h1234, 32'h55AA55AA, 1'b0);
    send_pixel(16'h1234, 32'hAA55AA55, 1'b0);
    send_pixel(16'h1234, 32'hFF0000FF, 1'b0);
    send_pixel(16'h1234, 32'h00FFFF00, 1'b0);
    send_pixel(16'h0002, 32'hFEFEFEFE, 1'b1);
    send_pixel(16'h0002, 32'h01FFFFFF, 1'b0);
    send_pixel(16'h0001, 32'hFFFFFFFF, 1'b1);
  endtask

  task automatic test_random_stacks(input int count, input int send_pct, input int recv_pct);
    int i;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (i = 0; i < count; i++) send_random_item();
  endtask

  // Hold the output off while items keep coming, so the core stalls its input
  task automatic test_output_stall();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    ready_hold_cycles = HOLD_CYCLES;
    for (i = 0; i < 40; i++) send_random_item();
  endtask

  // Let the core drain completely between short bursts
  task automatic test_drain_pauses();
    int round;
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 30;
    for (round = 0; round < 3; round++) begin
      for (i = 0; i < 20; i++) send_random_item();
      s_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clk);
    end
  endtask

  // Drive output ready: long hold when requested, random idling otherwise
  always @(posedge clk) begin
    if (ready_hold_cycles > 0) begin
      m_tready <= 1'b0;
      ready_hold_cycles = ready_hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each output item with the oldest predicted pixel
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("composite_pixel: no item expected, got %08h", m_tdata);
        mismatch_count++;
      end else begin
        expected_pixel = pending_pixels.pop_front();
        if (m_tdata !== expected_pixel) begin
          $error("composite_pixel: expected %08h, got %08h", expected_pixel, m_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    m_tready <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_stacks(600, 18, 82);
    test_random_stacks(600, 82, 18);
    test_output_stall();
    test_drain_pauses();
    test_random_stacks(550, 0, 0);

    // Drain, then let the clock run on for a tail to catch stray items
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/ftbo_pkg.sv
design/ftbo_ram.sv
design/ftbo_ctrl.sv
design/ftbo_dp.sv
design/front_to_back_over_compositor_core.sv
verif/tb_front_to_back_over_compositor_core.sv
